// ===== rtl/gae_pkg.sv =====
`default_nettype none
package gae_pkg;

  localparam int DEF_GRID_WIDTH  = 16;
  localparam int DEF_GRID_HEIGHT = 16;
  localparam int DEF_GRID_DEPTH  = 16;

  localparam int CELL_W     = 8;
  localparam int POS_W      = 4;
  localparam int KIND_W     = 2;
  localparam int MASK_W     = 27;
  localparam int NS_W       = 8;
  localparam int COUNT_W    = 5;
  localparam int COORD_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;

  localparam logic [CFG_IDX_W-1:0] CFG_BORN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATES  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GEN   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  localparam logic [NS_W-1:0] NS_RESET = 8'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic [CELL_W-1:0] cell_value;
  } gae_in_t;

  typedef struct packed {
    logic [CELL_W-1:0] read_value;
    logic [KIND_W-1:0] done_kind;
  } gae_out_t;

  typedef struct packed {
    logic take;
    logic clear_step;
    logic cell_write;
    logic read_issue;
    logic read_capture;
    logic nbr_step;
    logic cell_step;
    logic swap;
    logic load_out;
  } gae_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic nbr_last;
    logic cell_last;
    logic out_free;
  } gae_status_t;

  // Toroidal neighbor coordinate: d of 0, 1, 2 means c-1, c, c+1.
  function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_W-1:0] c,
                                                    input logic [1:0] d,
                                                    input logic [COORD_W-1:0] last);
    logic [COORD_W-1:0] r;
    r = c;
    if (d == 2'd0) begin
      r = (c == '0) ? last : c - 1'b1;
    end else if (d == 2'd2) begin
      r = (c == last) ? '0 : c + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [CELL_W-1:0] next_state(input logic [CELL_W-1:0] s,
                                                   input logic [COUNT_W-1:0] n,
                                                   input logic [MASK_W-1:0] born,
                                                   input logic [MASK_W-1:0] survive,
                                                   input logic [NS_W-1:0] ns);
    logic [CELL_W-1:0] r;
    if (s == 8'd1) begin
      if (survive[n]) begin
        r = 8'd1;
      end else begin
        r = (ns > 8'd2) ? ns - 1'b1 : '0;
      end
    end else if (s > 8'd2) begin
      r = s - 1'b1;
    end else if (s == 8'd2) begin
      r = '0;
    end else begin
      r = born[n] ? 8'd1 : 8'd0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/generations_automaton_3d_engine.sv =====
`default_nettype none
// Generations cellular automaton on a toroidal 3D grid with a 26-cell neighborhood.
// Requests arrive on the in channel (in_valid/in_ready, payload in_data) and each
// one that writes a cell, reads a cell or runs a generation returns one result
// request on the out channel (out_valid/out_ready, payload out_data). A request
// of kind 3 is taken and dropped without a result.
// Configuration (born mask, survive mask, state count) is written through
// cfg_we/cfg_index/cfg_data; index 3 is ignored. The user must write it only while
// the block is idle; the block itself does not enforce this. A generation visits
// every cell in turn, reading its 27-cell block from the source grid one cell per
// cycle on the single grid read port. One request is worked on at a time.
// After reset the block sweeps both grid memories to zero, one cell per cycle,
// and holds in_ready low meanwhile.
// The result sits in an output register; if the receiver stalls, the block takes
// one more request and then waits with that request's result until the
// register frees.
module generations_automaton_3d_engine import gae_pkg::*; #(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
  parameter int GRID_DEPTH  = DEF_GRID_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire gae_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output gae_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  gae_cmd_t    cmd;
  gae_status_t status;

  // The controller sequences the clear sweep and each request.
  gae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_data.kind),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds both grids, the scan counters, the neighbor count,
  // the configuration registers and the output register.
  gae_datapath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .GRID_DEPTH  (GRID_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire

// ===== rtl/gae_ram.sv =====
`default_nettype none
module gae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gae_datapath.sv =====
`default_nettype none
module gae_datapath import gae_pkg::*; #(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
  parameter int GRID_DEPTH  = DEF_GRID_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire gae_cmd_t              cmd,
  output gae_status_t                status,
  input  wire gae_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output gae_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT * GRID_DEPTH;
  localparam int AW    = $clog2(CELLS);
  localparam int PLANE = GRID_WIDTH * GRID_HEIGHT;
  localparam logic [COORD_W-1:0] X_LAST = COORD_W'(GRID_WIDTH - 1);
  localparam logic [COORD_W-1:0] Y_LAST = COORD_W'(GRID_HEIGHT - 1);
  localparam logic [COORD_W-1:0] Z_LAST = COORD_W'(GRID_DEPTH - 1);

  function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y,
                                               input logic [COORD_W-1:0] z);
    return AW'(int'(x) + int'(y) * GRID_WIDTH + int'(z) * PLANE);
  endfunction

  logic [MASK_W-1:0]  born_mask;
  logic [MASK_W-1:0]  survive_mask;
  logic [NS_W-1:0]    state_count;
  logic               sel;
  logic [AW-1:0]      clr_cnt;
  logic [COORD_W-1:0] cx, cy, cz;
  logic [1:0]         dx, dy, dz;
  logic               rd_pend, rd_center;
  logic [COUNT_W-1:0] live_cnt;
  logic [CELL_W-1:0]  center;
  logic [KIND_W-1:0]  kind_q;
  logic               in_grid_q;
  logic [CELL_W-1:0]  rd_hold;

  logic               in_grid;
  logic [AW-1:0]      pos_addr, nbr_addr, here_addr;
  logic [AW-1:0]      raddr, waddr;
  logic [CELL_W-1:0]  wdata;
  logic               re, we_a, we_b;
  logic [CELL_W-1:0]  rdata_a, rdata_b, src_data;

  assign in_grid = (int'(in_data.pos_x) < GRID_WIDTH) && (int'(in_data.pos_y) < GRID_HEIGHT) &&
                   (int'(in_data.pos_z) < GRID_DEPTH);
  assign pos_addr  = cell_addr(COORD_W'(in_data.pos_x), COORD_W'(in_data.pos_y),
                               COORD_W'(in_data.pos_z));
  assign nbr_addr  = cell_addr(wrap_coord(cx, dx, X_LAST), wrap_coord(cy, dy, Y_LAST),
                               wrap_coord(cz, dz, Z_LAST));
  assign here_addr = cell_addr(cx, cy, cz);

  assign re    = cmd.read_issue | cmd.nbr_step;
  assign raddr = cmd.read_issue ? pos_addr : nbr_addr;
  assign src_data = sel ? rdata_b : rdata_a;

  always_comb begin
    waddr = here_addr;
    wdata = next_state(center, live_cnt, born_mask, survive_mask, state_count);
    we_a  = 1'b0;
    we_b  = 1'b0;
    if (cmd.clear_step) begin
      waddr = clr_cnt;
      wdata = '0;
      we_a  = 1'b1;
      we_b  = 1'b1;
    end else if (cmd.cell_write) begin
      waddr = pos_addr;
      wdata = in_data.cell_value;
      we_a  = in_grid & ~sel;
      we_b  = in_grid & sel;
    end else if (cmd.cell_step) begin
      we_a  = sel;
      we_b  = ~sel;
    end
  end

  gae_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_grid_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata_a)
  );

  gae_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_grid_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata_b)
  );

  assign status.clear_last = (clr_cnt == AW'(CELLS - 1));
  assign status.nbr_last   = (dx == 2'd2) && (dy == 2'd2) && (dz == 2'd2);
  assign status.cell_last  = (cx == X_LAST) && (cy == Y_LAST) && (cz == Z_LAST);
  assign status.out_free   = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      born_mask    <= '0;
      survive_mask <= '0;
      state_count  <= NS_RESET;
      sel          <= 1'b0;
      clr_cnt      <= '0;
      cx           <= '0;
      cy           <= '0;
      cz           <= '0;
      dx           <= '0;
      dy           <= '0;
      dz           <= '0;
      rd_pend      <= 1'b0;
      live_cnt     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BORN:    born_mask    <= cfg_data[MASK_W-1:0];
          CFG_SURVIVE: survive_mask <= cfg_data[MASK_W-1:0];
          CFG_STATES:  state_count  <= cfg_data[NS_W-1:0];
          default:     ;
        endcase
      end
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.swap) begin
        sel <= ~sel;
      end
      rd_pend <= cmd.nbr_step;
      if (cmd.nbr_step) begin
        if (dx != 2'd2) begin
          dx <= dx + 1'b1;
        end else begin
          dx <= '0;
          if (dy != 2'd2) begin
            dy <= dy + 1'b1;
          end else begin
            dy <= '0;
            dz <= (dz != 2'd2) ? dz + 1'b1 : 2'd0;
          end
        end
      end
      if (rd_pend && !rd_center && src_data == 8'd1) begin
        live_cnt <= live_cnt + 1'b1;
      end
      if (cmd.cell_step) begin
        live_cnt <= '0;
        if (cx != X_LAST) begin
          cx <= cx + 1'b1;
        end else begin
          cx <= '0;
          if (cy != Y_LAST) begin
            cy <= cy + 1'b1;
          end else begin
            cy <= '0;
            cz <= (cz != Z_LAST) ? cz + 1'b1 : '0;
          end
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.nbr_step) begin
      rd_center <= (dx == 2'd1) && (dy == 2'd1) && (dz == 2'd1);
    end
    if (rd_pend && rd_center) begin
      center <= src_data;
    end
    if (cmd.take) begin
      kind_q    <= in_data.kind;
      in_grid_q <= in_grid;
    end
    if (cmd.read_capture) begin
      rd_hold <= in_grid_q ? src_data : '0;
    end
    if (cmd.load_out) begin
      out_data.read_value <= (kind_q == KIND_READ) ? rd_hold : '0;
      out_data.done_kind  <= kind_q;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gae_ctrl.sv =====
`default_nettype none
module gae_ctrl import gae_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire gae_status_t       status,
  output gae_cmd_t               cmd
);

  typedef enum logic [6:0] {
    S_CLEAR     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_READ      = 7'b0000100,
    S_GEN_NBR   = 7'b0001000,
    S_GEN_WAIT  = 7'b0010000,
    S_GEN_WRITE = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          case (in_kind)
            KIND_WRITE: begin
              cmd.cell_write = 1'b1;
              state_next     = S_DONE;
            end
            KIND_READ: begin
              cmd.read_issue = 1'b1;
              state_next     = S_READ;
            end
            KIND_GEN: state_next = S_GEN_NBR;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        cmd.read_capture = 1'b1;
        state_next       = S_DONE;
      end
      S_GEN_NBR: begin
        cmd.nbr_step = 1'b1;
        if (status.nbr_last) begin
          state_next = S_GEN_WAIT;
        end
      end
      S_GEN_WAIT: state_next = S_GEN_WRITE;
      S_GEN_WRITE: begin
        cmd.cell_step = 1'b1;
        if (status.cell_last) begin
          cmd.swap   = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_GEN_NBR;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== dv/automaton_checker.sv =====
`timescale 1ns / 1ps
module automaton_checker import gae_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire gae_in_t               in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire gae_out_t              out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         errors,
  output int                         outstanding
);

  localparam int SIDE  = 16;
  localparam int CELLS = SIDE * SIDE * SIDE;

  logic [CELL_W-1:0] cells [2][CELLS];
  logic              sel;
  logic [MASK_W-1:0] born;
  logic [MASK_W-1:0] survive;
  logic [NS_W-1:0]   states;
  gae_out_t          expected_results [$];

  function automatic int cell_at(int x, int y, int z);
    return ((x + SIDE) % SIDE) + ((y + SIDE) % SIDE) * SIDE + ((z + SIDE) % SIDE) * SIDE * SIDE;
  endfunction

  // One generation from the current grid into the other one, then swap.
  task automatic step_generation();
    int live;
    logic [CELL_W-1:0] s;
    for (int z = 0; z < SIDE; z++) begin
      for (int y = 0; y < SIDE; y++) begin
        for (int x = 0; x < SIDE; x++) begin
          live = 0;
          for (int dz = -1; dz <= 1; dz++)
            for (int dy = -1; dy <= 1; dy++)
              for (int dx = -1; dx <= 1; dx++)
                if ((dx != 0 || dy != 0 || dz != 0) &&
                    cells[sel][cell_at(x + dx, y + dy, z + dz)] == 8'd1)
                  live++;
          s = cells[sel][cell_at(x, y, z)];
          if (s == 8'd1) begin
            s = survive[live] ? 8'd1 : ((states > 8'd2) ? states - 8'd1 : 8'd0);
          end else if (s >= 8'd2) begin
            s = (s == 8'd2) ? 8'd0 : s - 8'd1;
          end else begin
            s = born[live] ? 8'd1 : 8'd0;
          end
          cells[!sel][cell_at(x, y, z)] = s;
        end
      end
    end
    sel = !sel;
  endtask

  always @(posedge clk) begin
    gae_out_t res;
    gae_out_t want;
    int idx;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        cells[0][i] = '0;
        cells[1][i] = '0;
      end
      sel = 1'b0;
      born = '0;
      survive = '0;
      states = NS_RESET;
      expected_results.delete();
      errors = 0;
      outstanding = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BORN:    born = cfg_data;
          CFG_SURVIVE: survive = cfg_data;
          CFG_STATES:  states = cfg_data[NS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: read_value %0d done_kind %0d",
                 out_data.read_value, out_data.done_kind);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_data.read_value);
            errors++;
          end
          if (out_data.done_kind !== want.done_kind) begin
            $error("done_kind: expected %0d, got %0d", want.done_kind, out_data.done_kind);
            errors++;
          end
        end
      end
      if (in_valid && in_ready && in_data.kind != KIND_NONE) begin
        idx = cell_at(int'(in_data.pos_x), int'(in_data.pos_y), int'(in_data.pos_z));
        res.read_value = '0;
        res.done_kind = in_data.kind;
        case (in_data.kind)
          KIND_WRITE: cells[sel][idx] = in_data.cell_value;
          KIND_READ:  res.read_value = cells[sel][idx];
          default:    step_generation();
        endcase
        expected_results.push_back(res);
      end
      outstanding = expected_results.size();
    end
  end

endmodule

// ===== dv/generations_automaton_3d_engine_tb.sv =====
`timescale 1ns / 1ps
module generations_automaton_3d_engine_tb import gae_pkg::*;;

  // The cycle limit allows for a handful of generations plus the short requests,
  // several times over.
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [MASK_W-1:0] ALL_COUNTS = 27'h7FFFFFF;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  gae_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  gae_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    errors;
  int                    outstanding;
  int                    cycles = 0;
  int                    stall_left = 0;
  // When set, the matching side never idles, so back-to-back traffic is covered.
  logic                  steady_send = 1'b0;
  logic                  steady_recv = 1'b0;
  int                    gens_left;

  always #5 clk = ~clk;

  generations_automaton_3d_engine i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  automaton_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  // The receiver draws a random stall after each result it takes, none when steady_recv is set.
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      n = steady_recv ? 0 : $urandom_range(0, 4);
      out_ready <= (n == 0);
      stall_left <= n;
    end else if (stall_left != 0) begin
      out_ready <= (stall_left == 1);
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the request was taken.
  // Valid is only lowered when a gap follows, so it is never dropped and raised
  // again within one step.
  task automatic send(input gae_in_t req);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic cell_req(input logic [KIND_W-1:0] k, input int x, input int y, input int z,
                          input int v);
    gae_in_t req;
    req.kind = k;
    req.pos_x = POS_W'(x);
    req.pos_y = POS_W'(y);
    req.pos_z = POS_W'(z);
    req.cell_value = CELL_W'(v);
    send(req);
  endtask

  // Waits for every outstanding result, plus a margin for a dropped request
  // that may still be in flight, and returns at a rising edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [MASK_W-1:0] b, input logic [MASK_W-1:0] s,
                           input logic [NS_W-1:0] ns);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BORN;
    cfg_data <= b;
    @(posedge clk);
    cfg_index <= CFG_SURVIVE;
    cfg_data <= s;
    @(posedge clk);
    cfg_index <= CFG_STATES;
    cfg_data <= CFG_DATA_W'(ns);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly writes of live cells and reads, so generations have patterns to
  // work on; dropped requests and a few generations are mixed in.
  task automatic random_phase(input int count);
    int pick;
    gae_in_t req;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      req.pos_x = POS_W'($urandom);
      req.pos_y = POS_W'($urandom);
      req.pos_z = POS_W'($urandom);
      req.cell_value = ($urandom_range(0, 9) < 6) ? 8'd1 : 8'($urandom);
      if (pick < 48) begin
        req.kind = KIND_WRITE;
      end else if (pick < 92) begin
        req.kind = KIND_READ;
      end else if (pick < 96 || gens_left == 0) begin
        req.kind = KIND_NONE;
      end else begin
        req.kind = KIND_GEN;
        gens_left--;
      end
      send(req);
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: empty masks, two states. Corner cells, the largest state,
    // a dropped request, then one generation in which everything decays.
    cell_req(KIND_WRITE, 0, 0, 0, 1);
    cell_req(KIND_WRITE, 15, 15, 15, 255);
    cell_req(KIND_WRITE, 15, 0, 15, 2);
    cell_req(KIND_WRITE, 0, 15, 0, 3);
    cell_req(KIND_READ, 0, 0, 0, 0);
    cell_req(KIND_READ, 15, 15, 15, 0);
    cell_req(KIND_NONE, 15, 15, 15, 0);
    cell_req(KIND_GEN, 0, 0, 0, 0);
    cell_req(KIND_READ, 0, 0, 0, 0);
    cell_req(KIND_READ, 15, 15, 15, 0);
    cell_req(KIND_READ, 15, 0, 15, 0);
    cell_req(KIND_READ, 0, 15, 0, 0);
    // The sender holds off here until every result is back.
    drain();

    // Full masks with a state count of zero, which acts as two; the unused
    // register index is written too and must have no effect.
    configure(ALL_COUNTS, ALL_COUNTS, 8'd0);
    cfg_we <= 1'b1;
    cfg_index <= CFG_UNUSED;
    cfg_data <= '1;
    @(posedge clk);
    cfg_we <= 1'b0;
    cell_req(KIND_WRITE, 7, 8, 9, 1);
    cell_req(KIND_GEN, 0, 0, 0, 0);
    cell_req(KIND_READ, 7, 8, 9, 0);
    cell_req(KIND_READ, 3, 3, 3, 0);
    drain();

    // Empty masks with the most states: every live cell becomes refractory.
    configure('0, '0, 8'd255);
    cell_req(KIND_GEN, 0, 0, 0, 0);
    cell_req(KIND_READ, 7, 8, 9, 0);
    cell_req(KIND_READ, 15, 15, 15, 0);
    drain();

    gens_left = 5;
    steady_send = 1'b1;
    steady_recv = 1'b1;
    configure(27'($urandom), 27'($urandom), 8'($urandom));
    random_phase(30);
    steady_send = 1'b0;
    steady_recv = 1'b0;
    configure(27'h10 | 27'h40, 27'h60 | 27'h100, 8'd1);
    random_phase(35);
    configure(27'h4, ALL_COUNTS, 8'd4);
    random_phase(35);
    steady_recv = 1'b1;
    configure(27'($urandom), 27'($urandom), 8'd255);
    random_phase(35);

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gae_pkg.sv
rtl/gae_ram.sv
rtl/gae_datapath.sv
rtl/gae_ctrl.sv
rtl/generations_automaton_3d_engine.sv
dv/automaton_checker.sv
dv/generations_automaton_3d_engine_tb.sv
